### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the paging unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock, quiet during reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent holds now, consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bmm_pkg.sv
// ---------------------------------------------------------------------------
// Paging unit package
// Word types, action codes and decode constants of the 128K memory mapper.
// ---------------------------------------------------------------------------
package bmm_pkg;

    // action codes
    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_PORT   = 2'd2;
    localparam logic [1:0] ACT_SCREEN = 2'd3;

    // CPU slot numbers (address[15:14])
    localparam logic [1:0] SLOT_ROM   = 2'd0;
    localparam logic [1:0] SLOT_FIXED = 2'd1;
    localparam logic [1:0] SLOT_MID   = 2'd2;
    localparam logic [1:0] SLOT_PAGED = 2'd3;

    localparam logic [2:0] BANK_SLOT1     = 3'd5;
    localparam logic [2:0] BANK_SLOT2     = 3'd2;
    localparam logic [2:0] BANK_SCREEN_LO = 3'd5;
    localparam logic [2:0] BANK_SCREEN_HI = 3'd7;

    localparam logic [15:0] PORT_MASK   = 16'hc002;
    localparam logic [15:0] PORT_MATCH  = 16'h4000;
    localparam logic [13:0] PIXEL_LIMIT = 14'h1b00;

    // paging byte layout
    localparam int DATA_SCREEN_BIT = 3;
    localparam int DATA_ROM_BIT    = 4;
    localparam int DATA_LOCK_BIT   = 5;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [15:0] port;
        logic [7:0]  data;
    } req_word_t;

    typedef struct packed {
        logic        to_rom;
        logic [2:0]  bank;
        logic [13:0] offset;
        logic        write_enable;
        logic        pixel_dirty;
        logic        refresh_all;
        logic        paging_taken;
    } rsp_word_t;

    typedef struct packed {
        logic [2:0] ram_page;
        logic [1:0] rom_select;
        logic       screen_is_seven;
        logic       paging_locked;
    } page_state_t;

endpackage

### sv/bmm_req_if.sv
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one access word into the mapper.
// ---------------------------------------------------------------------------
interface bmm_req_if;
    logic                valid;
    logic                ready;
    bmm_pkg::req_word_t  word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

### sv/bmm_rsp_if.sv
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one mapping result out of the mapper.
// ---------------------------------------------------------------------------
interface bmm_rsp_if;
    logic                valid;
    logic                ready;
    bmm_pkg::rsp_word_t  word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

### sv/bmm_map.sv
// ---------------------------------------------------------------------------
// Address mapper
// Maps one access word to bank/offset and computes the paging state update.
// ---------------------------------------------------------------------------
module bmm_map (
    input  bmm_pkg::req_word_t   item,
    input  bmm_pkg::page_state_t state,
    output bmm_pkg::rsp_word_t   result,
    output bmm_pkg::page_state_t state_next
);

    logic [2:0] shown_bank;
    logic [2:0] mem_bank;
    logic       mem_rom;
    logic       port_hit;

    assign shown_bank = state.screen_is_seven ? bmm_pkg::BANK_SCREEN_HI
                                              : bmm_pkg::BANK_SCREEN_LO;
    assign port_hit   = ((item.port & bmm_pkg::PORT_MASK) == bmm_pkg::PORT_MATCH)
                        && !state.paging_locked;

    always_comb
    begin
        mem_rom = 1'b0;
        unique case (item.address[15:14])
            bmm_pkg::SLOT_ROM:
            begin
                mem_rom  = 1'b1;
                mem_bank = {1'b0, state.rom_select};
            end
            bmm_pkg::SLOT_FIXED: mem_bank = bmm_pkg::BANK_SLOT1;
            bmm_pkg::SLOT_MID:   mem_bank = bmm_pkg::BANK_SLOT2;
            default:             mem_bank = state.ram_page;
        endcase
    end

    always_comb
    begin
        result     = '0;
        state_next = state;
        unique case (item.action)
            bmm_pkg::ACT_READ, bmm_pkg::ACT_WRITE:
            begin
                result.to_rom = mem_rom;
                result.bank   = mem_bank;
                result.offset = item.address[13:0];
                if (item.action == bmm_pkg::ACT_WRITE && !mem_rom)
                begin
                    result.write_enable = 1'b1;
                    result.pixel_dirty  = (mem_bank == shown_bank)
                                          && (item.address[13:0] < bmm_pkg::PIXEL_LIMIT);
                end
            end
            bmm_pkg::ACT_PORT:
            begin
                if (port_hit)
                begin
                    state_next.ram_page        = item.data[2:0];
                    state_next.screen_is_seven = item.data[bmm_pkg::DATA_SCREEN_BIT];
                    // rom bit 1 is kept, only bit 0 is loaded
                    state_next.rom_select      = {state.rom_select[1],
                                                  item.data[bmm_pkg::DATA_ROM_BIT]};
                    state_next.paging_locked   = item.data[bmm_pkg::DATA_LOCK_BIT];
                    result.paging_taken        = 1'b1;
                    result.refresh_all         = item.data[bmm_pkg::DATA_SCREEN_BIT]
                                                 ^ state.screen_is_seven;
                end
            end
            default:
            begin
                result.bank   = shown_bank;
                result.offset = item.address[13:0];
            end
        endcase
    end

endmodule

### sv/banked_memory_mapper_128k.sv
// ---------------------------------------------------------------------------
// 128K banked memory mapper
// Paging register and address decode for a banked 128K home computer.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one access word: memory read, memory write, port write or
//   screen fetch. rsp returns exactly one result word per request, in order.
//   A request word is registered on acceptance, mapped by one stage of
//   decode logic and lands in the output register: the result is valid on
//   rsp once the word is in the output register and can leave at the next edge.
//   Throughput is one word per cycle while rsp does not stall; the paging
//   register is updated as the word moves into the output register, so the
//   next word sees the new page. When rsp stalls, the output register holds
//   its word, the input register fills and req.ready drops only once both
//   are occupied. Reset clears the page, ROM select, screen select and lock
//   bit (screen bank 5 shown, unlocked) and empties both registers.
//   The lock bit, once set by a paging write, is cleared only by reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module banked_memory_mapper_128k (
    input  logic          clk,
    input  logic          rst_n,
    bmm_req_if.sink       req,
    bmm_rsp_if.source     rsp
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    bmm_pkg::req_word_t    in_word_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    bmm_pkg::rsp_word_t    out_word_reg;
    bmm_pkg::rsp_word_t    out_word_next;
    bmm_pkg::page_state_t  state_reg;
    bmm_pkg::page_state_t  map_state;
    bmm_pkg::page_state_t  state_next;
    logic                  advance;
    logic                  in_take;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign in_take   = req.valid && req.ready;

    bmm_map u_map (
        .item       (in_word_reg),
        .state      (state_reg),
        .result     (out_word_next),
        .state_next (map_state)
    );

    always_comb
    begin
        in_valid_next = in_take || (in_valid_reg && !advance);
        if (advance)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
        state_next = advance ? map_state : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_word_reg <= req.word;
        if (advance)
            out_word_reg <= out_word_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.word  = out_word_reg;

    `ASSERT_CLK(a_we_not_rom,
        !out_valid_reg || !(out_word_reg.write_enable && out_word_reg.to_rom),
        "RAM write flagged on a ROM access")
    `ASSERT_CLK(a_dirty_needs_we,
        !out_valid_reg || !out_word_reg.pixel_dirty || out_word_reg.write_enable,
        "dirty pixel without a RAM write")
    `ASSERT_CLK(a_refresh_needs_take,
        !out_valid_reg || !out_word_reg.refresh_all || out_word_reg.paging_taken,
        "refresh without an accepted paging write")
    `ASSERT_NEXT(a_lock_holds, state_reg.paging_locked, $stable(state_reg),
        "paging state changed while locked")
    `ASSERT_CLK(a_rom_hi_zero, !state_reg.rom_select[1], "ROM select bit 1 set")

endmodule

### bench/banked_memory_mapper_128k_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// 128K memory mapper testbench
// Drives reads, writes, port writes and screen fetches into the mapper and
// checks every result word against a behavioral model of the paging logic
// kept in step with the accepted requests.
// ---------------------------------------------------------------------------
module banked_memory_mapper_128k_test;

    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int REPORT_LIMIT  = 10;

    logic clk;
    logic rst_n;

    bmm_req_if req_ch ();
    bmm_rsp_if rsp_ch ();

    banked_memory_mapper_128k uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // model state and expected result words, oldest first
    bmm_pkg::page_state_t paging_reg;
    bmm_pkg::rsp_word_t   pending_maps[$];

    int idle_pct = 13;
    int hold_off_cycles = 0;
    int mismatches = 0;
    int unexpected = 0;
    int idle_count = 0;

    int sent_by_action[4];
    int seen_dirty = 0;
    int seen_refresh = 0;
    int seen_taken = 0;
    int seen_words = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Next result word for one request; updates the paging register copy.
    function automatic bmm_pkg::rsp_word_t map_access(input bmm_pkg::req_word_t w);
        bmm_pkg::rsp_word_t r;
        logic [2:0]         shown;
        logic               prev_screen;
        r = '0;
        shown = paging_reg.screen_is_seven ? bmm_pkg::BANK_SCREEN_HI
                                           : bmm_pkg::BANK_SCREEN_LO;
        case (w.action)
            bmm_pkg::ACT_READ, bmm_pkg::ACT_WRITE:
            begin
                r.offset = w.address[13:0];
                case (w.address[15:14])
                    bmm_pkg::SLOT_ROM:
                    begin
                        r.to_rom = 1'b1;
                        r.bank   = {1'b0, paging_reg.rom_select};
                    end
                    bmm_pkg::SLOT_FIXED: r.bank = bmm_pkg::BANK_SLOT1;
                    bmm_pkg::SLOT_MID:   r.bank = bmm_pkg::BANK_SLOT2;
                    default:             r.bank = paging_reg.ram_page;
                endcase
                if (w.action == bmm_pkg::ACT_WRITE && !r.to_rom)
                begin
                    r.write_enable = 1'b1;
                    r.pixel_dirty  = (r.bank == shown) && (r.offset < bmm_pkg::PIXEL_LIMIT);
                end
            end
            bmm_pkg::ACT_PORT:
            begin
                if ((w.port & bmm_pkg::PORT_MASK) == bmm_pkg::PORT_MATCH
                    && !paging_reg.paging_locked)
                begin
                    prev_screen                = paging_reg.screen_is_seven;
                    paging_reg.ram_page        = w.data[2:0];
                    paging_reg.screen_is_seven = w.data[bmm_pkg::DATA_SCREEN_BIT];
                    // ROM select bit 1 is never written
                    paging_reg.rom_select[0]   = w.data[bmm_pkg::DATA_ROM_BIT];
                    paging_reg.paging_locked   = w.data[bmm_pkg::DATA_LOCK_BIT];
                    r.paging_taken             = 1'b1;
                    r.refresh_all              = (prev_screen != paging_reg.screen_is_seven);
                end
            end
            default:
            begin
                r.bank   = shown;
                r.offset = w.address[13:0];
            end
        endcase
        return r;
    endfunction

    function automatic bmm_pkg::req_word_t mk_access(input logic [1:0] act,
                                                     input logic [15:0] addr,
                                                     input logic [15:0] prt,
                                                     input logic [7:0] dat);
        bmm_pkg::req_word_t w;
        w.action  = act;
        w.address = addr;
        w.port    = prt;
        w.data    = dat;
        return w;
    endfunction

    function automatic bmm_pkg::req_word_t random_access(input bit allow_lock);
        bmm_pkg::req_word_t w;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 30)
            w.action = bmm_pkg::ACT_READ;
        else if (pick < 65)
            w.action = bmm_pkg::ACT_WRITE;
        else if (pick < 80)
            w.action = bmm_pkg::ACT_PORT;
        else
            w.action = bmm_pkg::ACT_SCREEN;
        w.address = 16'($urandom);
        // aim at the pixel area boundary now and then
        if ($urandom_range(3) == 0)
            w.address[13:0] = bmm_pkg::PIXEL_LIMIT - 14'd4 + 14'($urandom_range(7));
        w.port = 16'($urandom);
        if ($urandom_range(1) == 1)
        begin
            w.port = (w.port & ~bmm_pkg::PORT_MASK) | bmm_pkg::PORT_MATCH;
        end
        w.data = 8'($urandom);
        if (!allow_lock)
            w.data[bmm_pkg::DATA_LOCK_BIT] = 1'b0;
        return w;
    endfunction

    // Offers one word; returns at the accepting edge with valid still high.
    task automatic send_access(input bmm_pkg::req_word_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.word  <= w;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_maps.push_back(map_access(w));
        sent_by_action[w.action]++;
    endtask

    task automatic send_random(input int count, input bit allow_lock);
        repeat (count) send_access(random_access(allow_lock));
    endtask

    task automatic test_directed();
        send_access(mk_access(bmm_pkg::ACT_READ,   16'h0000, 16'h0000, 8'h00));
        send_access(mk_access(bmm_pkg::ACT_READ,   16'hffff, 16'hffff, 8'hff));
        send_access(mk_access(bmm_pkg::ACT_WRITE,  16'h3fff, 16'h0000, 8'hff)); // dropped, ROM
        send_access(mk_access(bmm_pkg::ACT_WRITE,  16'h4000, 16'h0000, 8'h55));
        send_access(mk_access(bmm_pkg::ACT_WRITE,  16'h5aff, 16'h0000, 8'haa));
        send_access(mk_access(bmm_pkg::ACT_WRITE,  16'h5b00, 16'h0000, 8'h01));
        send_access(mk_access(bmm_pkg::ACT_WRITE,  16'h8000, 16'h0000, 8'h02));
        send_access(mk_access(bmm_pkg::ACT_WRITE,  16'hc000, 16'h0000, 8'h03));
        send_access(mk_access(bmm_pkg::ACT_SCREEN, 16'hffff, 16'h0000, 8'h00)); // offset wraps
        send_access(mk_access(bmm_pkg::ACT_PORT,   16'h0000, 16'hffff, 8'h1f)); // not decoded
        send_access(mk_access(bmm_pkg::ACT_PORT,   16'hffff, 16'h7ffd, 8'h1f)); // page 7, scr 7
        send_access(mk_access(bmm_pkg::ACT_READ,   16'h0123, 16'h0000, 8'h00));
        send_access(mk_access(bmm_pkg::ACT_WRITE,  16'hc000, 16'h0000, 8'h04));
        send_access(mk_access(bmm_pkg::ACT_WRITE,  16'h4000, 16'h0000, 8'h05));
        send_access(mk_access(bmm_pkg::ACT_WRITE,  16'hdaff, 16'h0000, 8'h06));
        send_access(mk_access(bmm_pkg::ACT_WRITE,  16'hdb00, 16'h0000, 8'h07));
        send_access(mk_access(bmm_pkg::ACT_SCREEN, 16'h0000, 16'h0000, 8'h00));
        send_access(mk_access(bmm_pkg::ACT_PORT,   16'h0000, 16'h4000, 8'h08)); // same screen
        send_access(mk_access(bmm_pkg::ACT_PORT,   16'h0000, 16'h4002, 8'h00));
        send_access(mk_access(bmm_pkg::ACT_PORT,   16'h0000, 16'hc000, 8'h00));
        send_access(mk_access(bmm_pkg::ACT_PORT,   16'h0000, 16'h0000, 8'h00));
        send_access(mk_access(bmm_pkg::ACT_PORT,   16'h0000, 16'hbffd, 8'h00));
        send_access(mk_access(bmm_pkg::ACT_PORT,   16'h0000, 16'h7ffd, 8'hc0)); // back to scr 5
    endtask

    task automatic test_random_mix();
        idle_pct = 13;
        send_random(1100, 1'b0);
    endtask

    task automatic test_no_idle_burst();
        idle_pct = 0;
        send_random(300, 1'b0);
        idle_pct = 13;
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        hold_off_cycles = 200;
        send_random(40, 1'b0);
    endtask

    // the lock survives until reset, so this runs last
    task automatic test_paging_lock();
        send_access(mk_access(bmm_pkg::ACT_PORT,  16'h0000, 16'h7ffd, 8'h3b));
        send_access(mk_access(bmm_pkg::ACT_PORT,  16'h0000, 16'h7ffd, 8'h00)); // ignored
        send_access(mk_access(bmm_pkg::ACT_READ,  16'h0000, 16'h0000, 8'h00));
        send_access(mk_access(bmm_pkg::ACT_WRITE, 16'hc010, 16'h0000, 8'h11));
        send_random(120, 1'b1);
    endtask

    // response side
    initial
    begin
        int n;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin
        bmm_pkg::rsp_word_t exp_w;
        bmm_pkg::rsp_word_t got_w;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_w = rsp_ch.word;
            seen_words++;
            if (pending_maps.size() == 0)
            begin
                unexpected++;
                $display("unexpected result word at %0t", $time);
            end
            else
            begin
                exp_w = pending_maps.pop_front();
                if (got_w.to_rom !== exp_w.to_rom || got_w.bank !== exp_w.bank
                    || got_w.offset !== exp_w.offset
                    || got_w.write_enable !== exp_w.write_enable
                    || got_w.pixel_dirty !== exp_w.pixel_dirty
                    || got_w.refresh_all !== exp_w.refresh_all
                    || got_w.paging_taken !== exp_w.paging_taken)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("mismatch at %0t: expected rom=%0d bank=%0d off=%h we=%0d %s",
                                 $time, exp_w.to_rom, exp_w.bank, exp_w.offset,
                                 exp_w.write_enable,
                                 $sformatf("dirty=%0d refresh=%0d taken=%0d",
                                           exp_w.pixel_dirty, exp_w.refresh_all,
                                           exp_w.paging_taken));
                        $display("    got rom=%0d bank=%0d off=%h we=%0d %s",
                                 got_w.to_rom, got_w.bank, got_w.offset,
                                 got_w.write_enable,
                                 $sformatf("dirty=%0d refresh=%0d taken=%0d",
                                           got_w.pixel_dirty, got_w.refresh_all,
                                           got_w.paging_taken));
                    end
                end
                seen_dirty   += exp_w.pixel_dirty;
                seen_refresh += exp_w.refresh_all;
                seen_taken   += exp_w.paging_taken;
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_count <= 0;
            else if (idle_count >= STALL_LIMIT)
            begin
                $display("no handshake for %0d cycles, %0d words outstanding",
                         STALL_LIMIT, pending_maps.size());
                $display("CHECK FAILED");
                $finish;
            end
            else
                idle_count <= idle_count + 1;
        end
    end

    initial
    begin
        int failures;
        paging_reg   = '0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.word  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix();
        test_no_idle_burst();
        test_backpressure();
        test_paging_lock();
        req_ch.valid <= 1'b0;

        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        failures = mismatches + unexpected + pending_maps.size();
        $display("%0d words: %0d reads, %0d writes, %0d port writes, %0d screen fetches",
                 seen_words, sent_by_action[bmm_pkg::ACT_READ],
                 sent_by_action[bmm_pkg::ACT_WRITE], sent_by_action[bmm_pkg::ACT_PORT],
                 sent_by_action[bmm_pkg::ACT_SCREEN]);
        $display("%0d dirty pixels, %0d full refreshes, %0d paging writes taken, %0d errors",
                 seen_dirty, seen_refresh, seen_taken, failures);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
